// ----- rtl/core/nbge_pkg.sv -----
// Shared constants, item types and controller/datapath command types for the n-body stepper.
`default_nettype none
package nbge_pkg;

  localparam int MAX_BODIES = 64;
  localparam int ADDR_W     = $clog2(MAX_BODIES);
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP  = 2'd0,
    CFG_GRAVITY    = 2'd1,
    CFG_BODY_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic               operation;
    logic [IDX_W-1:0]   body_index;
    logic [15:0]        mass;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_index;
    logic [15:0]        out_mass;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               overflow;
    logic               last;
  } out_item_t;

  typedef enum logic [4:0] {
    CMD_NOP        = 5'd0,
    CMD_LOAD       = 5'd1,
    CMD_READ       = 5'd2,
    CMD_LAT_I      = 5'd3,
    CMD_LAT_J      = 5'd4,
    CMD_SQ_MUL     = 5'd5,
    CMD_SQ_ACC     = 5'd6,
    CMD_GM_MUL     = 5'd7,
    CMD_GMD_MUL    = 5'd8,
    CMD_SQRT_GO    = 5'd9,
    CMD_SQRT_TAKE  = 5'd10,
    CMD_DIVA_GO    = 5'd11,
    CMD_DIVA_TAKE  = 5'd12,
    CMD_DIVU_GO    = 5'd13,
    CMD_DIVU_TAKE  = 5'd14,
    CMD_TMUL_LO    = 5'd15,
    CMD_TMUL_HI    = 5'd16,
    CMD_TERM       = 5'd17,
    CMD_FIN_V      = 5'd18,
    CMD_FIN_MUL    = 5'd19,
    CMD_FIN_POS    = 5'd20,
    CMD_EMIT       = 5'd21,
    CMD_COPY       = 5'd22
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        axis;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic             unit_done;
    logic             root_zero;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/nbge_if.sv -----
// Handshake channel interfaces: body input items, result items and configuration writes.
`default_nettype none
interface nbge_in_if;
  logic               valid;
  logic               ready;
  nbge_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface nbge_out_if;
  logic                valid;
  logic                ready;
  nbge_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface nbge_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/nbge_divsqrt.sv -----
// Shared iterative unit: restoring divide (one quotient bit a cycle) or integer square root.
`default_nettype none
module nbge_divsqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        is_sqrt,
  input  wire logic [63:0] num,
  input  wire logic [49:0] den,
  output logic             done,
  output logic [63:0]      quo
);
  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd25;

  logic        busy;
  logic        mode_sqrt;
  logic [6:0]  cnt;
  logic [63:0] x;
  logic [51:0] rem;
  logic [63:0] q;
  logic [49:0] den_r;

  logic [51:0] div_sh;
  logic        div_ge;
  logic [51:0] sq_sh;
  logic [51:0] sq_trial;
  logic        sq_ge;

  always_comb begin
    div_sh   = {rem[50:0], x[63]};
    div_ge   = div_sh >= {2'b00, den_r};
    sq_sh    = {rem[49:0], x[63:62]};
    sq_trial = {25'd0, q[24:0], 2'b01};
    sq_ge    = sq_sh >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= is_sqrt ? SQRT_STEPS : DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_sqrt <= is_sqrt;
      x         <= is_sqrt ? {num[49:0], 14'd0} : num;
      rem       <= '0;
      q         <= '0;
      den_r     <= den;
    end else if (busy) begin
      if (mode_sqrt) begin
        rem <= sq_ge ? sq_sh - sq_trial : sq_sh;
        q   <= {q[62:0], sq_ge};
        x   <= {x[61:0], 2'b00};
      end else begin
        rem <= div_ge ? div_sh - {2'b00, den_r} : div_sh;
        q   <= {q[62:0], div_ge};
        x   <= {x[62:0], 1'b0};
      end
    end
  end

  assign quo = q;
endmodule
`default_nettype wire

// ----- rtl/core/nbge_dp.sv -----
// Datapath: body stores, pair arithmetic, velocity/position update, config and result registers.
`default_nettype none
module nbge_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire nbge_pkg::cmd_t     cmd,
  output nbge_pkg::stat_t         stat,
  input  wire nbge_pkg::in_item_t req_item,
  nbge_cfg_if.sink                cfg,
  nbge_out_if.source              result
);
  import nbge_pkg::*;

  // configuration
  logic [15:0]      dt;
  logic [31:0]      grav;
  logic [6:0]       body_count;

  // stores
  logic signed [31:0] pos_mem  [3][MAX_BODIES];
  logic signed [31:0] vel_mem  [3][MAX_BODIES];
  logic signed [31:0] pend_mem [3][MAX_BODIES];
  logic [15:0]        mass_mem [MAX_BODIES];
  logic signed [31:0] pos_rd  [3];
  logic signed [31:0] vel_rd  [3];
  logic signed [31:0] pend_rd [3];
  logic [15:0]        mass_rd;

  // working registers
  logic signed [31:0] pi   [3];
  logic signed [56:0] acc  [3];
  logic signed [32:0] dd   [3];
  logic signed [31:0] vnew [3];
  logic signed [31:0] np   [3];
  logic [15:0]        mi;
  logic [15:0]        mj;
  logic [49:0]        r2;
  logic [63:0]        prod;
  logic [47:0]        gm;
  logic [63:0]        gmd;
  logic [24:0]        r8;
  logic [47:0]        a;
  logic [16:0]        u;
  logic [40:0]        plo;
  logic [40:0]        phi;
  logic               ovf;

  logic               out_valid;
  out_item_t          out_item;

  // unit interface
  logic               unit_start;
  logic               unit_sqrt;
  logic [63:0]        unit_num;
  logic [49:0]        unit_den;
  logic               unit_done;
  logic [63:0]        unit_quo;

  logic signed [31:0] req_pos [3];
  logic signed [31:0] req_vel [3];
  logic               is_load;
  logic [ADDR_W-1:0]  load_addr;

  logic signed [32:0] cur_d;
  logic [32:0]        neg_d;
  logic [31:0]        mag_d;
  logic signed [56:0] cur_acc;
  logic [64:0]        term_full;
  logic [48:0]        term_t;
  logic signed [56:0] term_s;
  logic               acc_fits;
  logic signed [31:0] acc_sat;
  logic signed [31:0] cur_v;
  logic [31:0]        mag_v;
  logic [31:0]        dm;
  logic signed [33:0] pos_sum;
  logic               pos_fits;
  logic signed [31:0] pos_sat;
  logic [6:0]         n_sat;

  always_comb begin
    req_pos[0] = req_item.pos_x;
    req_pos[1] = req_item.pos_y;
    req_pos[2] = req_item.pos_z;
    req_vel[0] = req_item.vel_x;
    req_vel[1] = req_item.vel_y;
    req_vel[2] = req_item.vel_z;
    is_load    = cmd.op == CMD_LOAD;
    load_addr  = req_item.body_index[ADDR_W-1:0];

    cur_d   = dd[cmd.axis];
    neg_d   = -cur_d;
    mag_d   = cur_d[32] ? neg_d[31:0] : cur_d[31:0];
    cur_acc = acc[cmd.axis];

    term_full = {phi, 24'd0} + {24'd0, plo};
    term_t    = term_full[63:15];
    term_s    = signed'({8'd0, term_t});

    acc_fits = cur_acc[56:31] == {26{cur_acc[56]}};
    acc_sat  = cur_acc[56] ? 32'sh8000_0000 : 32'sh7fff_ffff;

    cur_v = vnew[cmd.axis];
    mag_v = cur_v[31] ? 32'(-cur_v) : cur_v;
    dm    = prod[47:16];

    pos_sum  = cur_v[31] ? 34'(pi[cmd.axis]) - signed'({2'b00, dm})
                         : 34'(pi[cmd.axis]) + signed'({2'b00, dm});
    pos_fits = pos_sum[33:31] == {3{pos_sum[33]}};
    pos_sat  = pos_sum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;

    unit_start = (cmd.op == CMD_SQRT_GO) || (cmd.op == CMD_DIVA_GO) ||
                 (cmd.op == CMD_DIVU_GO);
    unit_sqrt  = cmd.op == CMD_SQRT_GO;
    unit_num   = (cmd.op == CMD_DIVU_GO) ? {25'd0, mag_d, 7'd0} :
                 (cmd.op == CMD_DIVA_GO) ? gmd : {14'd0, r2};
    unit_den   = (cmd.op == CMD_DIVU_GO) ? {25'd0, r8} : r2;

    n_sat = (body_count > 7'(MAX_BODIES)) ? 7'(MAX_BODIES) : body_count;
  end

  nbge_divsqrt u_divsqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .is_sqrt (unit_sqrt),
    .num     (unit_num),
    .den     (unit_den),
    .done    (unit_done),
    .quo     (unit_quo)
  );

  // config port, always ready
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dt         <= 16'd328;
      grav       <= 32'd65536;
      body_count <= 7'd64;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_TIME_STEP)  dt         <= cfg.data[15:0];
      if (cfg.index == CFG_GRAVITY)    grav       <= cfg.data;
      if (cfg.index == CFG_BODY_COUNT) body_count <= cfg.data[6:0];
    end
  end

  // stores, one write and one registered read each
  for (genvar g = 0; g < 3; g++) begin : g_axis
    always_ff @(posedge clk) begin
      if (is_load) begin
        pos_mem[g][load_addr] <= req_pos[g];
      end else if (cmd.op == CMD_COPY) begin
        pos_mem[g][cmd.addr] <= pend_rd[g];
      end
      pos_rd[g] <= pos_mem[g][cmd.addr];
    end
    always_ff @(posedge clk) begin
      if (is_load) begin
        vel_mem[g][load_addr] <= req_vel[g];
      end else if (cmd.op == CMD_EMIT) begin
        vel_mem[g][cmd.addr] <= vnew[g];
      end
      vel_rd[g] <= vel_mem[g][cmd.addr];
    end
    always_ff @(posedge clk) begin
      if (cmd.op == CMD_EMIT) begin
        pend_mem[g][cmd.addr] <= np[g];
      end
      pend_rd[g] <= pend_mem[g][cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (is_load) begin
      mass_mem[load_addr] <= req_item.mass;
    end
    mass_rd <= mass_mem[cmd.addr];
  end

  // pair and update arithmetic
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LAT_I: begin
        for (int g = 0; g < 3; g++) begin
          pi[g]  <= pos_rd[g];
          acc[g] <= 57'(vel_rd[g]);
        end
        mi  <= mass_rd;
        ovf <= 1'b0;
      end
      CMD_LAT_J: begin
        for (int g = 0; g < 3; g++) begin
          dd[g] <= 33'(pos_rd[g]) - 33'(pi[g]);
        end
        mj <= mass_rd;
        r2 <= '0;
      end
      CMD_SQ_MUL:  prod <= {32'd0, mag_d} * {32'd0, mag_d};
      CMD_SQ_ACC:  r2 <= r2 + {2'b00, prod[63:16]};
      CMD_GM_MUL:  gm <= {16'd0, grav} * {32'd0, mj};
      CMD_GMD_MUL: gmd <= {16'd0, gm} * {48'd0, dt};
      CMD_SQRT_TAKE: begin
        if (unit_done) r8 <= unit_quo[24:0];
      end
      CMD_DIVA_TAKE: begin
        if (unit_done) begin
          a <= ((|unit_quo[63:48]) || (unit_quo[47] && (|unit_quo[46:0])))
               ? 48'h8000_0000_0000 : unit_quo[47:0];
        end
      end
      CMD_DIVU_TAKE: begin
        if (unit_done) begin
          u <= ((|unit_quo[63:17]) || (unit_quo[16] && (|unit_quo[15:0])))
               ? 17'h10000 : unit_quo[16:0];
        end
      end
      CMD_TMUL_LO: plo <= {17'd0, a[23:0]} * {24'd0, u};
      CMD_TMUL_HI: phi <= {17'd0, a[47:24]} * {24'd0, u};
      CMD_TERM: begin
        acc[cmd.axis] <= cur_d[32] ? cur_acc - term_s : cur_acc + term_s;
      end
      CMD_FIN_V: begin
        vnew[cmd.axis] <= acc_fits ? cur_acc[31:0] : acc_sat;
        if (!acc_fits) ovf <= 1'b1;
      end
      CMD_FIN_MUL: prod <= {32'd0, mag_v} * {48'd0, dt};
      CMD_FIN_POS: begin
        np[cmd.axis] <= pos_fits ? pos_sum[31:0] : pos_sat;
        if (!pos_fits) ovf <= 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == CMD_EMIT) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_EMIT) begin
      out_item.out_index <= IDX_W'(cmd.addr);
      out_item.out_mass  <= mi;
      out_item.new_pos_x <= np[0];
      out_item.new_pos_y <= np[1];
      out_item.new_pos_z <= np[2];
      out_item.new_vel_x <= vnew[0];
      out_item.new_vel_y <= vnew[1];
      out_item.new_vel_z <= vnew[2];
      out_item.overflow  <= ovf;
      out_item.last      <= cmd.last;
    end
  end

  assign result.valid = out_valid;
  assign result.item  = out_item;

  always_comb begin
    stat.unit_done = unit_done;
    stat.root_zero = unit_quo[24:0] == 25'd0;
    stat.out_free  = !out_valid || result.ready;
    stat.count     = CNT_W'(n_sat);
  end
endmodule
`default_nettype wire

// ----- rtl/core/nbge_ctrl.sv -----
// Controller: sequences loads, the pair loops of a step, result emission and the position copy.
`default_nettype none
module nbge_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  input  wire logic            req_op,
  output logic                 req_ready,
  input  wire nbge_pkg::stat_t stat,
  output nbge_pkg::cmd_t       cmd
);
  import nbge_pkg::*;

  typedef enum logic [24:0] {
    S_IDLE      = 25'h0000001,
    S_RD_I      = 25'h0000002,
    S_LAT_I     = 25'h0000004,
    S_J_SEL     = 25'h0000008,
    S_RD_J      = 25'h0000010,
    S_LAT_J     = 25'h0000020,
    S_SQ_MUL    = 25'h0000040,
    S_SQ_ACC    = 25'h0000080,
    S_GM_MUL    = 25'h0000100,
    S_GMD_MUL   = 25'h0000200,
    S_SQRT_GO   = 25'h0000400,
    S_SQRT_WAIT = 25'h0000800,
    S_DIVA_GO   = 25'h0001000,
    S_DIVA_WAIT = 25'h0002000,
    S_DIVU_GO   = 25'h0004000,
    S_DIVU_WAIT = 25'h0008000,
    S_TMUL_LO   = 25'h0010000,
    S_TMUL_HI   = 25'h0020000,
    S_TERM      = 25'h0040000,
    S_FIN_V     = 25'h0080000,
    S_FIN_MUL   = 25'h0100000,
    S_FIN_POS   = 25'h0200000,
    S_EMIT      = 25'h0400000,
    S_CP_RD     = 25'h0800000,
    S_CP_WR     = 25'h1000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] i, i_next;
  logic [CNT_W-1:0] j, j_next;
  logic [1:0]       k, k_next;
  logic             i_is_last;

  assign i_is_last = (i + CNT_W'(1)) == stat.count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    req_ready  = 1'b0;
    cmd.op     = CMD_NOP;
    cmd.addr   = i[ADDR_W-1:0];
    cmd.axis   = k;
    cmd.last   = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_op == OP_LOAD) begin
            cmd.op = CMD_LOAD;
          end else if (stat.count != '0) begin
            i_next     = '0;
            state_next = S_RD_I;
          end
        end
      end
      S_RD_I: begin
        cmd.op     = CMD_READ;
        state_next = S_LAT_I;
      end
      S_LAT_I: begin
        cmd.op     = CMD_LAT_I;
        j_next     = '0;
        state_next = S_J_SEL;
      end
      S_J_SEL: begin
        priority if (j == stat.count) begin
          k_next     = '0;
          state_next = S_FIN_V;
        end else if (j == i) begin
          j_next = j + CNT_W'(1);
        end else begin
          state_next = S_RD_J;
        end
      end
      S_RD_J: begin
        cmd.op     = CMD_READ;
        cmd.addr   = j[ADDR_W-1:0];
        state_next = S_LAT_J;
      end
      S_LAT_J: begin
        cmd.op     = CMD_LAT_J;
        k_next     = '0;
        state_next = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd.op     = CMD_SQ_MUL;
        state_next = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd.op = CMD_SQ_ACC;
        if (k == 2'd2) begin
          state_next = S_GM_MUL;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_SQ_MUL;
        end
      end
      S_GM_MUL: begin
        cmd.op     = CMD_GM_MUL;
        state_next = S_GMD_MUL;
      end
      S_GMD_MUL: begin
        cmd.op     = CMD_GMD_MUL;
        state_next = S_SQRT_GO;
      end
      S_SQRT_GO: begin
        cmd.op     = CMD_SQRT_GO;
        state_next = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        cmd.op = CMD_SQRT_TAKE;
        if (stat.unit_done) begin
          if (stat.root_zero) begin
            j_next     = j + CNT_W'(1);
            state_next = S_J_SEL;
          end else begin
            state_next = S_DIVA_GO;
          end
        end
      end
      S_DIVA_GO: begin
        cmd.op     = CMD_DIVA_GO;
        state_next = S_DIVA_WAIT;
      end
      S_DIVA_WAIT: begin
        cmd.op = CMD_DIVA_TAKE;
        if (stat.unit_done) begin
          k_next     = '0;
          state_next = S_DIVU_GO;
        end
      end
      S_DIVU_GO: begin
        cmd.op     = CMD_DIVU_GO;
        state_next = S_DIVU_WAIT;
      end
      S_DIVU_WAIT: begin
        cmd.op = CMD_DIVU_TAKE;
        if (stat.unit_done) state_next = S_TMUL_LO;
      end
      S_TMUL_LO: begin
        cmd.op     = CMD_TMUL_LO;
        state_next = S_TMUL_HI;
      end
      S_TMUL_HI: begin
        cmd.op     = CMD_TMUL_HI;
        state_next = S_TERM;
      end
      S_TERM: begin
        cmd.op = CMD_TERM;
        if (k == 2'd2) begin
          j_next     = j + CNT_W'(1);
          state_next = S_J_SEL;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_DIVU_GO;
        end
      end
      S_FIN_V: begin
        cmd.op     = CMD_FIN_V;
        state_next = S_FIN_MUL;
      end
      S_FIN_MUL: begin
        cmd.op     = CMD_FIN_MUL;
        state_next = S_FIN_POS;
      end
      S_FIN_POS: begin
        cmd.op = CMD_FIN_POS;
        if (k == 2'd2) begin
          state_next = S_EMIT;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_FIN_V;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op   = CMD_EMIT;
          cmd.last = i_is_last;
          if (i_is_last) begin
            i_next     = '0;
            state_next = S_CP_RD;
          end else begin
            i_next     = i + CNT_W'(1);
            state_next = S_RD_I;
          end
        end
      end
      S_CP_RD: begin
        cmd.op     = CMD_READ;
        state_next = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.op = CMD_COPY;
        if (i_is_last) begin
          state_next = S_IDLE;
        end else begin
          i_next     = i + CNT_W'(1);
          state_next = S_CP_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/nbody_gravity_euler_step_top.sv -----
// Top level of the direct-sum n-body gravity stepper (semi-implicit Euler, Q16.16).
//
// Channels: request carries load and step items, result carries one item per
// body after a step, cfg writes time_step (0), gravity_constant (1) and
// body_count (2); other indexes are dropped. cfg is always ready.
// A load item is stored as it is accepted and yields nothing. A step item walks every
// ordered pair (i, j) of the first n bodies; each pair runs through one shared
// divide/root unit that retires one quotient or root bit per cycle: a root and,
// unless the root is zero, a divide for G*m*dt/r^2 and three divides for d/r.
// Body i is emitted as soon as its update finishes; the last carries last=1.
// After the last result the new positions are copied back body by body,
// with request held not ready.
// If the receiver stalls, the result register holds and the step waits
// before emitting the next body. Reset restores the register defaults
// (dt 328, G 1.0, 64 bodies) and idles the sequencer; body stores are not
// cleared and must be loaded before use.
`default_nettype none
module nbody_gravity_euler_step_top (
  input  wire logic clk,
  input  wire logic rst,
  nbge_in_if.sink   request,
  nbge_out_if.source result,
  nbge_cfg_if.sink  cfg
);
  import nbge_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: owns the loop counters and the request handshake
  nbge_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_op    (request.item.operation),
    .req_ready (request.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: stores, arithmetic, config registers and result register
  nbge_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_item (request.item),
    .cfg      (cfg),
    .result   (result)
  );
endmodule
`default_nettype wire

// ----- tb/nbge_step_checker.sv -----
// Watches the n-body stepper channels, predicts every result item and compares it.
`timescale 1ns / 1ps
module nbge_step_checker
  import nbge_pkg::*;
(
  input  logic clk,
  input  logic rst,
  nbge_in_if   request,
  nbge_out_if  result,
  nbge_cfg_if  cfg,
  output int   fail_count,
  output int   pending,
  output int   result_count
);

  longint unsigned dt_q, grav_q, count_q;
  longint unsigned mass_mem [MAX_BODIES];
  longint          pos_mem  [MAX_BODIES][3];
  longint          vel_mem  [MAX_BODIES][3];
  out_item_t       body_updates [$];

  assign pending = body_updates.size();

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint sat32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // One full Euler step; positions come from the start of the step.
  function automatic void advance_bodies();
    longint unsigned n, r2, r8, a, u, t, dm;
    longint          d [3];
    longint          acc [3];
    longint          np [MAX_BODIES][3];
    bit              ovf;
    out_item_t       o;
    n = (count_q > MAX_BODIES) ? MAX_BODIES : count_q;
    for (int i = 0; i < n; i++) begin
      ovf = 0;
      for (int k = 0; k < 3; k++) acc[k] = vel_mem[i][k];
      for (int j = 0; j < n; j++) begin
        if (j == i) continue;
        r2 = 0;
        for (int k = 0; k < 3; k++) begin
          d[k] = pos_mem[j][k] - pos_mem[i][k];
          r2 += (mag(d[k]) * mag(d[k])) >> 16;
        end
        r8 = isqrt(r2);
        if (r8 == 0) continue;  // pair with a zero root pulls nothing
        a = grav_q * mass_mem[j] * dt_q / r2;
        if (a > (64'd1 << 47)) a = 64'd1 << 47;
        for (int k = 0; k < 3; k++) begin
          u = (mag(d[k]) << 7) / r8;
          if (u > 65536) u = 65536;
          t = (a * u) >> 15;
          if (d[k] < 0) acc[k] -= t;
          else acc[k] += t;
        end
      end
      for (int k = 0; k < 3; k++) begin
        acc[k] = sat32(acc[k], ovf);
        dm = (mag(acc[k]) * dt_q) >> 16;
        np[i][k] = sat32(pos_mem[i][k] + ((acc[k] < 0) ? -longint'(dm) : longint'(dm)), ovf);
        vel_mem[i][k] = acc[k];
      end
      o.out_index = i;
      o.out_mass  = mass_mem[i];
      o.new_pos_x = np[i][0];
      o.new_pos_y = np[i][1];
      o.new_pos_z = np[i][2];
      o.new_vel_x = acc[0];
      o.new_vel_y = acc[1];
      o.new_vel_z = acc[2];
      o.overflow  = ovf;
      o.last      = (i + 1 == n);
      body_updates.push_back(o);
    end
    for (int i = 0; i < n; i++)
      for (int k = 0; k < 3; k++) pos_mem[i][k] = np[i][k];
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  task automatic check_field(string field, longint got, longint want);
    if (got != want) report_mismatch(field, got, want);
  endtask

  always @(posedge clk) begin
    out_item_t got, want;
    in_item_t  it;
    if (rst) begin
      dt_q    <= 328;
      grav_q  <= 65536;
      count_q <= 64;
      body_updates.delete();
      fail_count   <= 0;
      result_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_TIME_STEP:  dt_q    <= cfg.data[15:0];
          CFG_GRAVITY:    grav_q  <= cfg.data;
          CFG_BODY_COUNT: count_q <= cfg.data[6:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        got = result.item;
        result_count <= result_count + 1;
        if (body_updates.size() == 0) begin
          report_mismatch("unexpected result, out_index", got.out_index, 0);
        end else begin
          want = body_updates.pop_front();
          check_field("out_index", got.out_index, want.out_index);
          check_field("out_mass",  got.out_mass,  want.out_mass);
          check_field("new_pos_x", got.new_pos_x, want.new_pos_x);
          check_field("new_pos_y", got.new_pos_y, want.new_pos_y);
          check_field("new_pos_z", got.new_pos_z, want.new_pos_z);
          check_field("new_vel_x", got.new_vel_x, want.new_vel_x);
          check_field("new_vel_y", got.new_vel_y, want.new_vel_y);
          check_field("new_vel_z", got.new_vel_z, want.new_vel_z);
          check_field("overflow",  got.overflow,  want.overflow);
          check_field("last",      got.last,      want.last);
        end
      end
      if (request.valid && request.ready) begin
        it = request.item;
        if (it.operation == OP_LOAD) begin
          mass_mem[it.body_index]   = it.mass;
          pos_mem[it.body_index][0] = it.pos_x;
          pos_mem[it.body_index][1] = it.pos_y;
          pos_mem[it.body_index][2] = it.pos_z;
          vel_mem[it.body_index][0] = it.vel_x;
          vel_mem[it.body_index][1] = it.vel_y;
          vel_mem[it.body_index][2] = it.vel_z;
        end else begin
          advance_bodies();
        end
      end
    end
  end

endmodule

// ----- tb/nbody_gravity_euler_step_top_tb.sv -----
// Stimulus and verdict for the n-body stepper: loads, steps, config sweeps, idle mixes.
`timescale 1ns / 1ps
module nbody_gravity_euler_step_top_tb;
  import nbge_pkg::*;

  // index 3 is outside the register list and must be dropped
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam longint CYCLE_LIMIT = 8_000_000;
  // copy-back after the last result: a read and a write state per body, plus margin
  localparam int SETTLE_CYCLES = 2 * MAX_BODIES + 16;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending, result_count;
  int   send_idle_pct = 0, recv_stall_pct = 0;
  int   cur_count = 64;
  int   loads_sent = 0, steps_sent = 0;
  bit   loaded [MAX_BODIES];
  longint cycles = 0;

  nbge_in_if  request ();
  nbge_out_if result ();
  nbge_cfg_if cfg ();

  nbody_gravity_euler_step_top u_dut (
    .clk(clk), .rst(rst), .request(request), .result(result), .cfg(cfg)
  );

  nbge_step_checker u_checker (
    .clk(clk), .rst(rst), .request(request), .result(result), .cfg(cfg),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watchdog: a hung handshake or a stuck step ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("nbody_gravity_euler_step_top test failed");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    request.valid = 0;
    request.item  = '0;
    cfg.valid = 0;
    cfg.index = CFG_TIME_STEP;
    cfg.data  = 0;
  end

  // Request goes quiet first so no item rides along with a register write.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    request.valid <= 1'b0;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == CFG_BODY_COUNT) cur_count = data[6:0];
  endtask

  // Holds valid high after acceptance so back-to-back items need no bubble.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      request.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    request.valid <= 1'b1;
    request.item  <= it;
    do @(posedge clk); while (!request.ready);
  endtask

  // Mostly modest coordinates so the pull is visible; sometimes any 32-bit word.
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  task automatic load_body(int idx, logic [15:0] m, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
                           logic [31:0] vz);
    in_item_t it;
    it = '{operation: OP_LOAD, body_index: idx, mass: m, pos_x: px, pos_y: py,
           pos_z: pz, vel_x: vx, vel_y: vy, vel_z: vz};
    send_item(it);
    loaded[idx] = 1;
    loads_sent++;
  endtask

  task automatic load_random(int idx);
    load_body(idx, ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300)),
              rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord());
  endtask

  // Every active slot must hold a body before a step walks it.
  task automatic run_step();
    in_item_t it;
    int n;
    n = (cur_count > MAX_BODIES) ? MAX_BODIES : cur_count;
    for (int i = 0; i < n; i++)
      if (!loaded[i]) load_random(i);
    it = '0;
    it.operation  = OP_STEP;
    it.body_index = $urandom;
    it.mass       = $urandom;
    it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
    it.vel_x = $urandom; it.vel_y = $urandom; it.vel_z = $urandom;
    send_item(it);
    steps_sent++;
  endtask

  // Sender holds off until every predicted body has come back and copy-back is done.
  // It first lets the checker queue the predictions of the last item.
  task automatic drain();
    request.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int send_mix [4] = '{0, 76, 0, 10};
    int recv_mix [4] = '{0, 0, 76, 10};
    logic [31:0] g;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, zero mass, a coincident pair.
    load_body(0, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    load_body(1, 16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 0);
    load_body(2, 16'd100, 0, 0, 0, 32'h0001_0000, 0, 0);
    load_body(3, 16'd500, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    load_body(4, 16'd1000, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 0, 0, 0);
    cfg_write(CFG_BODY_COUNT, 5);
    run_step();                 // reset dt and G
    drain();
    cfg_write(CFG_TIME_STEP, 1);
    cfg_write(CFG_GRAVITY, 1);
    run_step();
    drain();
    cfg_write(CFG_TIME_STEP, 16'hFFFF);
    cfg_write(CFG_GRAVITY, 32'hFFFF_FFFF);
    run_step();                 // heavy saturation
    drain();
    cfg_write(CFG_TIME_STEP, 0);
    cfg_write(CFG_GRAVITY, 0);
    run_step();                 // no acceleration at all
    drain();
    cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
    cfg_write(CFG_BODY_COUNT, 0);
    run_step();                 // empty step, nothing comes back
    drain();
    cfg_write(CFG_TIME_STEP, 328);
    cfg_write(CFG_GRAVITY, 32'h0001_0000);
    cfg_write(CFG_BODY_COUNT, 1);
    run_step();                 // lone body just drifts
    drain();
    cfg_write(CFG_BODY_COUNT, 7'h7F);
    run_step();                 // oversized count clamps to the full store
    drain();

    // Random phases, one per idle mix, each with fresh registers.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_mix[p];
      recv_stall_pct = recv_mix[p];
      for (int sub = 0; sub < 2; sub++) begin
        drain();
        cfg_write(CFG_TIME_STEP, $urandom_range(1, 65535));
        g = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 32'h0010_0000);
        cfg_write(CFG_GRAVITY, g);
        cfg_write(CFG_BODY_COUNT, ($urandom_range(7) == 0) ? 8 : $urandom_range(2, 6));
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(99) < 65) load_random($urandom_range(0, cur_count + 1));
          else run_step();
        end
      end
    end
    drain();

    $display("Covered %0d loads and %0d steps, %0d body results, four idle mixes.",
             loads_sent, steps_sent, result_count);
    if (fail_count == 0) begin
      $display("nbody_gravity_euler_step_top test passed");
    end else begin
      $display("nbody_gravity_euler_step_top test failed");
    end
    $finish;
  end

endmodule
